// File: hw/rtl/tfnb_pkg.sv
package tfnb_pkg;

    // Sample and configuration widths
    localparam int SAMPLE_W  = 16;
    localparam int ACC_W     = SAMPLE_W + 2;
    localparam int DIM_CFG_W = 7;
    localparam int PASS_W    = 8;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PASS_COUNT = 2'd2;

    // Frame memory selection
    localparam logic FRAME_A = 1'b0;
    localparam logic FRAME_B = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_BLUR,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_WAIT_IN
    } state_t;

    // Sub-steps of one blurred cell: four neighbor reads, then the write
    typedef enum logic [2:0] {
        STEP_UP,
        STEP_DOWN,
        STEP_LEFT,
        STEP_RIGHT,
        STEP_WRITE
    } step_t;

    typedef struct packed {
        logic wr_en;
        logic wr_sel;
        logic rd_en;
        logic rd_sel;
    } frame_ctrl_t;

endpackage

// File: hw/rtl/tfnb_frames.sv
module tfnb_frames #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic                          clk,
    input  tfnb_pkg::frame_ctrl_t         ctrl,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [tfnb_pkg::SAMPLE_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [tfnb_pkg::SAMPLE_W-1:0] rd_data
);

    logic [tfnb_pkg::SAMPLE_W-1:0] frame_a [DEPTH];
    logic [tfnb_pkg::SAMPLE_W-1:0] frame_b [DEPTH];
    logic [tfnb_pkg::SAMPLE_W-1:0] q_a_reg;
    logic [tfnb_pkg::SAMPLE_W-1:0] q_b_reg;
    logic                          sel_reg;

    // Write the selected frame
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en && (ctrl.wr_sel == tfnb_pkg::FRAME_A))
        begin
            frame_a[wr_addr] <= wr_data;
        end
        if (ctrl.wr_en && (ctrl.wr_sel == tfnb_pkg::FRAME_B))
        begin
            frame_b[wr_addr] <= wr_data;
        end
    end

    // Read both frames; hold the data until the next read
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            q_a_reg <= frame_a[rd_addr];
            q_b_reg <= frame_b[rd_addr];
            sel_reg <= ctrl.rd_sel;
        end
    end

    assign rd_data = (sel_reg == tfnb_pkg::FRAME_B) ? q_b_reg : q_a_reg;

endmodule

// File: hw/rtl/toroidal_four_neighbour_blur_top.sv
// Toroidal four-neighbor blur.
// Input stream (s_*): one 16-bit sample per word, row-major. While loading the
// block takes one word per cycle into frame A. After the last cell of a
// map_width x map_height map it runs pass_count blur passes (zero runs one)
// with s_tready low. Each cell becomes the truncated mean of its four wrapped
// neighbors; one shared adder serves four frame reads and one write per cell.
// Output stream (m_*): row 0 follows the blur, then each further input word
// (its value is ignored) releases the next row of map_width words. Every
// output word is read from the frame, then presented; a stall on m_tready
// holds m_tdata and m_tlast. m_tlast marks the final cell, after which the
// block loads a new map.
// Config port: write map_width (0), map_height (1) or pass_count (2) while
// idle; any write to one of them restarts loading. Reset sets 64 x 64, one
// pass, and loading from cell 0. Frame contents are not cleared.
module toroidal_four_neighbour_blur_top #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // s_tdata: [15:0] sample_in
    input  logic [15:0]                    s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // m_tdata: [15:0] sample_out; m_tlast: last_cell
    output logic [15:0]                    m_tdata,
    output logic                           m_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_wr_en,
    input  logic [tfnb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tfnb_pkg::CFG_W-1:0]     cfg_data
);

    localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int DW_W   = $clog2(MAX_WIDTH + 1);
    localparam int DH_W   = $clog2(MAX_HEIGHT + 1);
    localparam int PROD_W = DW_W + DH_W;
    localparam int SW     = tfnb_pkg::SAMPLE_W;

    // Configuration registers
    logic [tfnb_pkg::DIM_CFG_W-1:0] map_width_reg;
    logic [tfnb_pkg::DIM_CFG_W-1:0] map_height_reg;
    logic [tfnb_pkg::PASS_W-1:0]    pass_count_reg;
    logic                           cfg_hit;

    // Sequencer state
    tfnb_pkg::state_t state_reg, state_next;
    tfnb_pkg::step_t  step_reg, step_next;
    logic [CNT_W-1:0]           cell_reg, cell_next;
    logic [CNT_W-1:0]           base_reg, base_next;
    logic [DW_W-1:0]            x_reg, x_next;
    logic [tfnb_pkg::PASS_W-1:0] pass_reg, pass_next;
    logic                       src_reg, src_next;
    logic [tfnb_pkg::ACC_W-1:0] acc_reg, acc_next;

    // Geometry
    logic [31:0]                 w_raw;
    logic [31:0]                 h_raw;
    logic [DW_W-1:0]             eff_w;
    logic [DH_W-1:0]             eff_h;
    logic [CNT_W-1:0]            total;
    logic [CNT_W-1:0]            w_ext;
    logic [CNT_W-1:0]            x_ext;
    logic [tfnb_pkg::PASS_W-1:0] pass_target;

    // Neighbor addressing
    logic [CNT_W-1:0]           row_next;
    logic [CNT_W-1:0]           up_addr;
    logic [CNT_W-1:0]           down_addr;
    logic [CNT_W-1:0]           left_addr;
    logic [CNT_W-1:0]           right_addr;
    logic                       x_last;
    logic                       cell_last;
    logic                       row_last;
    logic                       pass_last;
    logic [tfnb_pkg::ACC_W-1:0] sum;

    // Frame port
    tfnb_pkg::frame_ctrl_t ctrl;
    logic [ADDR_W-1:0]     wr_addr;
    logic [SW-1:0]         wr_data;
    logic [ADDR_W-1:0]     rd_addr;
    logic [SW-1:0]         rd_data;

    assign cfg_hit = cfg_wr_en && ((cfg_index == tfnb_pkg::CFG_MAP_WIDTH)
                  || (cfg_index == tfnb_pkg::CFG_MAP_HEIGHT)
                  || (cfg_index == tfnb_pkg::CFG_PASS_COUNT));

    // Capture configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= 7'd64;
            map_height_reg <= 7'd64;
            pass_count_reg <= 8'd1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                tfnb_pkg::CFG_MAP_WIDTH:
                begin
                    map_width_reg <= cfg_data[tfnb_pkg::DIM_CFG_W-1:0];
                end
                tfnb_pkg::CFG_MAP_HEIGHT:
                begin
                    map_height_reg <= cfg_data[tfnb_pkg::DIM_CFG_W-1:0];
                end
                tfnb_pkg::CFG_PASS_COUNT:
                begin
                    pass_count_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Clamp dimensions to 1..max and derive the cell count
    assign w_raw = 32'(map_width_reg);
    assign h_raw = 32'(map_height_reg);

    always_comb
    begin
        priority if (w_raw == 32'd0)
        begin
            eff_w = DW_W'(1);
        end
        else if (w_raw > 32'(MAX_WIDTH))
        begin
            eff_w = DW_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = DW_W'(w_raw);
        end

        priority if (h_raw == 32'd0)
        begin
            eff_h = DH_W'(1);
        end
        else if (h_raw > 32'(MAX_HEIGHT))
        begin
            eff_h = DH_W'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = DH_W'(h_raw);
        end
    end

    assign total       = CNT_W'(PROD_W'(eff_w) * PROD_W'(eff_h));
    assign w_ext       = CNT_W'(eff_w);
    assign x_ext       = CNT_W'(x_reg);
    assign pass_target = (pass_count_reg == '0) ? 8'd1 : pass_count_reg;

    // Wrapped neighbor addresses of the current cell
    assign row_next   = base_reg + w_ext;
    assign row_last   = (row_next == total);
    assign up_addr    = ((base_reg == '0) ? (total - w_ext) : (base_reg - w_ext)) + x_ext;
    assign down_addr  = (row_last ? '0 : row_next) + x_ext;
    assign left_addr  = (x_reg == '0) ? (row_next - CNT_W'(1))
                                      : (base_reg + x_ext - CNT_W'(1));
    assign x_last     = ({1'b0, x_reg} + (DW_W + 1)'(1)) == {1'b0, eff_w};
    assign right_addr = x_last ? base_reg : (base_reg + x_ext + CNT_W'(1));
    assign cell_last  = (cell_reg + CNT_W'(1)) == total;
    assign pass_last  = (pass_reg + 8'd1) == pass_target;

    // Shared adder: first neighbor starts the sum
    assign sum = ((step_reg == tfnb_pkg::STEP_DOWN) ? '0 : acc_reg)
               + tfnb_pkg::ACC_W'(rd_data);

    // Advance the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tfnb_pkg::ST_LOAD;
            step_reg  <= tfnb_pkg::STEP_UP;
            cell_reg  <= '0;
            base_reg  <= '0;
            x_reg     <= '0;
            pass_reg  <= '0;
            src_reg   <= tfnb_pkg::FRAME_A;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            cell_reg  <= cell_next;
            base_reg  <= base_next;
            x_reg     <= x_next;
            pass_reg  <= pass_next;
            src_reg   <= src_next;
        end
    end

    // Hold the partial sum
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // Next state, frame accesses and handshakes
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cell_next  = cell_reg;
        base_next  = base_reg;
        x_next     = x_reg;
        pass_next  = pass_reg;
        src_next   = src_reg;
        acc_next   = acc_reg;
        ctrl       = '0;
        wr_addr    = cell_reg[ADDR_W-1:0];
        wr_data    = s_tdata[SW-1:0];
        rd_addr    = cell_reg[ADDR_W-1:0];
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;

        unique case (state_reg)
            tfnb_pkg::ST_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctrl.wr_en  = 1'b1;
                    ctrl.wr_sel = tfnb_pkg::FRAME_A;
                    if (cell_last)
                    begin
                        cell_next  = '0;
                        base_next  = '0;
                        x_next     = '0;
                        pass_next  = '0;
                        src_next   = tfnb_pkg::FRAME_A;
                        step_next  = tfnb_pkg::STEP_UP;
                        state_next = tfnb_pkg::ST_BLUR;
                    end
                    else
                    begin
                        cell_next = cell_reg + CNT_W'(1);
                    end
                end
            end

            tfnb_pkg::ST_BLUR:
            begin
                ctrl.rd_sel = src_reg;
                if (step_reg != tfnb_pkg::STEP_UP)
                begin
                    acc_next = sum;
                end
                unique case (step_reg)
                    tfnb_pkg::STEP_UP:
                    begin
                        ctrl.rd_en = 1'b1;
                        rd_addr    = up_addr[ADDR_W-1:0];
                        step_next  = tfnb_pkg::STEP_DOWN;
                    end
                    tfnb_pkg::STEP_DOWN:
                    begin
                        ctrl.rd_en = 1'b1;
                        rd_addr    = down_addr[ADDR_W-1:0];
                        step_next  = tfnb_pkg::STEP_LEFT;
                    end
                    tfnb_pkg::STEP_LEFT:
                    begin
                        ctrl.rd_en = 1'b1;
                        rd_addr    = left_addr[ADDR_W-1:0];
                        step_next  = tfnb_pkg::STEP_RIGHT;
                    end
                    tfnb_pkg::STEP_RIGHT:
                    begin
                        ctrl.rd_en = 1'b1;
                        rd_addr    = right_addr[ADDR_W-1:0];
                        step_next  = tfnb_pkg::STEP_WRITE;
                    end
                    tfnb_pkg::STEP_WRITE:
                    begin
                        // Store the mean into the other frame, move to the next cell
                        ctrl.wr_en  = 1'b1;
                        ctrl.wr_sel = ~src_reg;
                        wr_data     = sum[tfnb_pkg::ACC_W-1:2];
                        step_next   = tfnb_pkg::STEP_UP;
                        cell_next   = cell_reg + CNT_W'(1);
                        if (x_last)
                        begin
                            x_next = '0;
                            if (row_last)
                            begin
                                base_next = '0;
                                cell_next = '0;
                                src_next  = ~src_reg;
                                pass_next = pass_reg + 8'd1;
                                if (pass_last)
                                begin
                                    state_next = tfnb_pkg::ST_EMIT_RD;
                                end
                            end
                            else
                            begin
                                base_next = row_next;
                            end
                        end
                        else
                        begin
                            x_next = x_reg + DW_W'(1);
                        end
                    end
                    default:
                    begin
                        step_next = tfnb_pkg::STEP_UP;
                    end
                endcase
            end

            tfnb_pkg::ST_EMIT_RD:
            begin
                ctrl.rd_en  = 1'b1;
                ctrl.rd_sel = src_reg;
                state_next  = tfnb_pkg::ST_EMIT_OUT;
            end

            tfnb_pkg::ST_EMIT_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    priority if (cell_last)
                    begin
                        cell_next  = '0;
                        x_next     = '0;
                        state_next = tfnb_pkg::ST_LOAD;
                    end
                    else if (x_last)
                    begin
                        cell_next  = cell_reg + CNT_W'(1);
                        x_next     = '0;
                        state_next = tfnb_pkg::ST_WAIT_IN;
                    end
                    else
                    begin
                        cell_next  = cell_reg + CNT_W'(1);
                        x_next     = x_reg + DW_W'(1);
                        state_next = tfnb_pkg::ST_EMIT_RD;
                    end
                end
            end

            tfnb_pkg::ST_WAIT_IN:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = tfnb_pkg::ST_EMIT_RD;
                end
            end

            default:
            begin
                state_next = tfnb_pkg::ST_LOAD;
            end
        endcase

        // Drop the current frame on a configuration write
        if (cfg_hit)
        begin
            state_next = tfnb_pkg::ST_LOAD;
            cell_next  = '0;
            x_next     = '0;
            pass_next  = '0;
        end
    end

    assign m_tdata = rd_data;
    assign m_tlast = cell_last;

    tfnb_frames #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_frames (
        .clk     (clk),
        .ctrl    (ctrl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// File: tb/sv/blur_map_checker.sv
`timescale 1ns / 100ps

// Watches both streams and the register port, predicts the blurred map and
// compares every output word against it.
module blur_map_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [15:0]                    s_tdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [15:0]                    m_tdata,
    input  logic                           m_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_wr_en,
    input  logic [tfnb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tfnb_pkg::CFG_W-1:0]     cfg_data,
    output int                             cells_pending,
    output int                             mismatch_count
);

    localparam int MAX_DIM    = 64;
    localparam int MAX_CELLS  = MAX_DIM * MAX_DIM;

    typedef enum logic {
        LOADING,
        EMITTING
    } fill_phase_t;

    typedef struct packed {
        logic [tfnb_pkg::SAMPLE_W-1:0] sample;
        logic                          last;
    } cell_word_t;

    logic [tfnb_pkg::DIM_CFG_W-1:0] width_reg;
    logic [tfnb_pkg::DIM_CFG_W-1:0] height_reg;
    logic [tfnb_pkg::PASS_W-1:0]    passes_reg;
    fill_phase_t                    fill_phase;
    int                             fill_count;

    logic [tfnb_pkg::SAMPLE_W-1:0]  loaded_map  [MAX_CELLS];
    logic [tfnb_pkg::SAMPLE_W-1:0]  blurred_map [MAX_CELLS];
    logic [tfnb_pkg::SAMPLE_W-1:0]  scratch_map [MAX_CELLS];

    cell_word_t           expected_cells [$];
    cell_word_t           head;
    logic                 restart;

    // Zero reads as one, anything past the array size saturates
    function automatic int used_dim(input logic [tfnb_pkg::DIM_CFG_W-1:0] code);
        if (code == 0)
            return 1;
        if (int'(code) > MAX_DIM)
            return MAX_DIM;
        return int'(code);
    endfunction

    // Run all passes on the loaded map; each cell takes the floored mean of its
    // four wrapped neighbors, the cell itself is left out
    function automatic void blur_frame(input int w, input int h);
        int                          rounds;
        int                          up;
        int                          down;
        int                          left;
        int                          right;
        logic [tfnb_pkg::ACC_W-1:0]  sum;
        rounds = (passes_reg == 0) ? 1 : int'(passes_reg);
        for (int i = 0; i < w * h; i++)
            blurred_map[i] = loaded_map[i];
        for (int r = 0; r < rounds; r++)
        begin
            for (int y = 0; y < h; y++)
            begin
                up   = (y == 0) ? h - 1 : y - 1;
                down = (y + 1 >= h) ? 0 : y + 1;
                for (int x = 0; x < w; x++)
                begin
                    left  = (x == 0) ? w - 1 : x - 1;
                    right = (x + 1 >= w) ? 0 : x + 1;
                    sum = tfnb_pkg::ACC_W'(blurred_map[up * w + x])
                        + tfnb_pkg::ACC_W'(blurred_map[down * w + x])
                        + tfnb_pkg::ACC_W'(blurred_map[y * w + left])
                        + tfnb_pkg::ACC_W'(blurred_map[y * w + right]);
                    scratch_map[y * w + x] = sum[tfnb_pkg::ACC_W-1:2];
                end
            end
            for (int i = 0; i < w * h; i++)
                blurred_map[i] = scratch_map[i];
        end
    endfunction

    // Queue the next row of the blurred map; flag the final cell
    function automatic void queue_row(input int w, input int total);
        cell_word_t entry;
        for (int k = 0; k < w; k++)
        begin
            entry.sample = blurred_map[fill_count];
            entry.last   = (fill_count == total - 1);
            expected_cells.insert(expected_cells.size(), entry);
            fill_count++;
        end
        if (fill_count >= total)
        begin
            fill_count = 0;
            fill_phase = LOADING;
        end
    endfunction

    // Store one loaded cell, or release a row while emitting
    function automatic void take_word(input logic [tfnb_pkg::SAMPLE_W-1:0] value);
        int w;
        int h;
        w = used_dim(width_reg);
        h = used_dim(height_reg);
        if (fill_phase == LOADING)
        begin
            loaded_map[fill_count] = value;
            fill_count++;
            if (fill_count < w * h)
                return;
            blur_frame(w, h);
            fill_phase = EMITTING;
            fill_count = 0;
        end
        queue_row(w, w * h);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            width_reg      = 7'd64;
            height_reg     = 7'd64;
            passes_reg     = 8'd1;
            fill_phase     = LOADING;
            fill_count     = 0;
            mismatch_count = 0;
            expected_cells.delete();
        end
        else
        begin
            // Apply a register write; a write that hits a register drops the map
            if (cfg_wr_en)
            begin
                restart = 1'b1;
                case (cfg_index)
                    tfnb_pkg::CFG_MAP_WIDTH:
                        width_reg  = cfg_data[tfnb_pkg::DIM_CFG_W-1:0];
                    tfnb_pkg::CFG_MAP_HEIGHT:
                        height_reg = cfg_data[tfnb_pkg::DIM_CFG_W-1:0];
                    tfnb_pkg::CFG_PASS_COUNT:
                        passes_reg = cfg_data[tfnb_pkg::PASS_W-1:0];
                    default:
                        restart    = 1'b0;
                endcase
                if (restart)
                begin
                    fill_count = 0;
                    fill_phase = LOADING;
                end
            end

            if (s_tvalid && s_tready)
                take_word(s_tdata);

            // Compare each output word with the oldest expected cell
            if (m_tvalid && m_tready)
            begin
                if (expected_cells.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected word: expected none, actual sample %h last %b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    head = expected_cells.pop_front();
                    if (m_tdata !== head.sample)
                    begin
                        mismatch_count++;
                        $display("%0t: sample_out: expected %h, actual %h",
                                 $time, head.sample, m_tdata);
                    end
                    if (m_tlast !== head.last)
                    begin
                        mismatch_count++;
                        $display("%0t: last_cell: expected %b, actual %b",
                                 $time, head.last, m_tlast);
                    end
                end
            end
        end
        cells_pending = expected_cells.size();
    end

endmodule

// File: tb/sv/tb_toroidal_four_neighbour_blur_top.sv
`timescale 1ns / 100ps

module tb_toroidal_four_neighbour_blur_top;

    localparam int MAX_DIM       = 64;
    localparam int ITEM_TARGET   = 330;
    localparam int QUIET_FROM    = 290;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 40;
    localparam int CYCLE_LIMIT   = 1000000;

    // Index past the last register; writes to it must be ignored
    localparam logic [tfnb_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic [15:0]                    s_tdata   = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [15:0]                    m_tdata;
    logic                           m_tlast;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [tfnb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tfnb_pkg::CFG_W-1:0]     cfg_data  = '0;

    int                   cells_pending;
    int                   mismatch_count;
    int                   items_sent  = 0;
    int                   cycle_count = 0;
    int                   stall_left  = 0;
    logic                 quiet_tail  = 1'b0;

    always #5 clk = ~clk;

    toroidal_four_neighbour_blur_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    blur_map_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tdata        (s_tdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cells_pending  (cells_pending),
        .mismatch_count (mismatch_count)
    );

    // Stall the output side in bursts of random length, none in the tail
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 4);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Mostly uniform samples, with the two extremes mixed in
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Encode a dimension: one may go as zero, the maximum as any larger code;
    // the top bit is not part of the register and is left random
    function automatic logic [7:0] dim_code(input int dim);
        logic [6:0] code;
        if (dim == MAX_DIM)
            code = 7'($urandom_range(MAX_DIM, 127));
        else if (dim == 1 && $urandom_range(0, 1) == 0)
            code = 7'd0;
        else
            code = 7'(dim);
        return {1'($urandom_range(0, 1)), code};
    endfunction

    // Offer one word, with an optional idle burst first; hold until accepted
    task automatic send_word(input logic [15:0] value);
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    // Hold off until every expected cell has come out
    task automatic wait_drained();
        @(negedge clk);
        while (cells_pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    // Write one register while the block is idle
    task automatic write_reg(input logic [tfnb_pkg::CFG_IDX_W-1:0] index,
                             input logic [tfnb_pkg::CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Load some cells, then send words that release further rows
    task automatic play_frame(input int load_words, input int row_words);
        for (int i = 0; i < load_words; i++)
            send_word(pick_sample());
        for (int i = 0; i < row_words; i++)
            send_word(16'($urandom));
    endtask

    initial
    begin
        int   w;
        int   h;
        int   total;
        logic [7:0] passes;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single cell, zero passes: the cell averages four copies of itself
        write_reg(tfnb_pkg::CFG_MAP_WIDTH, 8'd1);
        write_reg(tfnb_pkg::CFG_MAP_HEIGHT, 8'd1);
        write_reg(tfnb_pkg::CFG_PASS_COUNT, 8'd0);
        send_word(16'hFFFF);

        // Zero width reads as one column; two rows, three passes
        write_reg(tfnb_pkg::CFG_MAP_WIDTH, 8'd0);
        write_reg(tfnb_pkg::CFG_MAP_HEIGHT, 8'd2);
        write_reg(tfnb_pkg::CFG_PASS_COUNT, 8'd3);
        play_frame(0, 0);
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word(16'h1234);

        // 3 x 3, one pass, extreme samples
        write_reg(tfnb_pkg::CFG_MAP_WIDTH, 8'd3);
        write_reg(tfnb_pkg::CFG_MAP_HEIGHT, 8'd3);
        write_reg(tfnb_pkg::CFG_PASS_COUNT, 8'd1);
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word(16'h0001);
        send_word(16'h8000);
        send_word(16'hFFFF);
        send_word(16'h0000);
        send_word(16'h7FFF);
        send_word(16'hFFFE);
        send_word(16'hAAAA);
        send_word(16'h5555);
        send_word(16'hFFFF);

        // 2 x 2 at the maximum pass count; a spare-index write mid-load keeps
        // the partial map, a real write drops it
        write_reg(tfnb_pkg::CFG_MAP_WIDTH, 8'd2);
        write_reg(tfnb_pkg::CFG_MAP_HEIGHT, 8'd2);
        write_reg(tfnb_pkg::CFG_PASS_COUNT, 8'd255);
        send_word(16'hFFFF);
        send_word(16'h0000);
        write_reg(CFG_SPARE, 8'hFF);
        send_word(16'h8001);
        write_reg(tfnb_pkg::CFG_PASS_COUNT, 8'd255);
        play_frame(4, 1);

        // Oversized codes saturate: one wide row, then one tall column
        write_reg(tfnb_pkg::CFG_MAP_WIDTH, 8'hFF);
        write_reg(tfnb_pkg::CFG_MAP_HEIGHT, 8'd1);
        write_reg(tfnb_pkg::CFG_PASS_COUNT, 8'd2);
        play_frame(MAX_DIM, 0);
        write_reg(tfnb_pkg::CFG_MAP_WIDTH, 8'd1);
        write_reg(tfnb_pkg::CFG_MAP_HEIGHT, 8'hE4);
        write_reg(tfnb_pkg::CFG_PASS_COUNT, 8'd1);
        play_frame(MAX_DIM, MAX_DIM - 1);

        // Random small maps, some dropped while loading or between rows
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= QUIET_FROM)
                quiet_tail = 1'b1;
            w     = $urandom_range(1, 6);
            h     = $urandom_range(1, 6);
            total = w * h;
            if (total <= 4 && $urandom_range(0, 3) == 0)
                passes = 8'($urandom_range(0, 255));
            else
                passes = 8'($urandom_range(0, 3));
            if ($urandom_range(0, 5) == 0)
                write_reg(CFG_SPARE, 8'($urandom));
            write_reg(tfnb_pkg::CFG_MAP_WIDTH, dim_code(w));
            write_reg(tfnb_pkg::CFG_MAP_HEIGHT, dim_code(h));
            write_reg(tfnb_pkg::CFG_PASS_COUNT, passes);
            case ($urandom_range(0, 7))
                0: play_frame($urandom_range(0, total - 1), 0);
                1: play_frame(total, (h > 1) ? $urandom_range(0, h - 2) : 0);
                default: play_frame(total, h - 1);
            endcase
        end

        // Drain, let the block settle, then give the verdict
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: toroidal_four_neighbour_blur_top.f
hw/rtl/tfnb_pkg.sv
hw/rtl/tfnb_frames.sv
hw/rtl/toroidal_four_neighbour_blur_top.sv
tb/sv/blur_map_checker.sv
tb/sv/tb_toroidal_four_neighbour_blur_top.sv
